// ===== rtl/cmm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cmm_pkg;

   // Schedule table size and derived index width
   localparam int ENTRIES     = 16;
   localparam int ENTRY_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   // Field widths fixed by the interface
   localparam int CMD_W       = 3;
   localparam int SEL_W       = 4;
   localparam int MASK_W      = 60;
   localparam int HOUR_MASK_W = 24;
   localparam int DAY_MASK_W  = 31;
   localparam int MON_MASK_W  = 12;
   localparam int WD_MASK_W   = 7;
   localparam int YEAR_W      = 12;
   localparam int MONTH_W     = 4;
   localparam int DAY_W       = 5;
   localparam int HOUR_W      = 5;
   localparam int MINUTE_W    = 6;
   localparam int WEEKDAY_W   = 3;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 12;

   // Request queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Command codes
   localparam logic [CMD_W-1:0] CMD_LOAD_MINUTE  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD_HOUR    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_LOAD_DAY     = 3'd2;
   localparam logic [CMD_W-1:0] CMD_LOAD_MONTH   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_LOAD_WEEKDAY = 3'd4;
   localparam logic [CMD_W-1:0] CMD_RESTART      = 3'd5;
   localparam logic [CMD_W-1:0] CMD_TICK         = 3'd6;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_START_YEAR   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_MONTH  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_START_DAY    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_START_HOUR   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_START_MINUTE = 3'd4;

   // Clock reset values
   localparam logic [YEAR_W-1:0]    EPOCH_YEAR    = 12'd1970;
   localparam logic [YEAR_W-1:0]    MAX_YEAR      = 12'd4095;
   localparam logic [WEEKDAY_W-1:0] EPOCH_WEEKDAY = 3'd4;
   localparam logic [6:0]           EPOCH_MOD100  = 7'd70;
   localparam logic [8:0]           EPOCH_MOD400  = 9'd370;

   typedef enum logic [1:0] {
      KIND_LOAD,
      KIND_RESTART,
      KIND_TICK
   } kind_type;

   typedef enum logic [2:0] {
      FLD_MINUTE,
      FLD_HOUR,
      FLD_DAY,
      FLD_MONTH,
      FLD_WEEKDAY
   } field_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_RS_YEAR,
      BK_RS_MONTH,
      BK_SCAN,
      BK_FLUSH
   } back_state_type;

   typedef struct packed {
      kind_type                kind;
      field_type               field;
      logic [ENTRY_W-1:0]      sel;
      logic [MASK_W-1:0]       mask;
   } op_type;

   typedef struct packed {
      logic   valid;
      op_type op;
   } q_entry_type;

   function automatic logic is_leap(input logic [6:0] mod100, input logic [8:0] mod400);
      return ((mod100[1:0] == 2'd0) && (mod100 != 7'd0)) || (mod400 == 9'd0);
   endfunction

   function automatic logic [DAY_W-1:0] days_in(input logic leap,
                                               input logic [MONTH_W-1:0] month);
      logic [DAY_W-1:0] d;
      case (month)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
         4'd2:                                       d = leap ? 5'd29 : 5'd28;
         default:                                    d = 5'd0;
      endcase
      return d;
   endfunction

   // Residue mod 7 of a value below 112 by weighted subtraction
   function automatic logic [WEEKDAY_W-1:0] mod7(input logic [6:0] v);
      logic [6:0] r;
      r = v;
      if (r >= 7'd56) r = r - 7'd56;
      if (r >= 7'd28) r = r - 7'd28;
      if (r >= 7'd14) r = r - 7'd14;
      if (r >= 7'd7)  r = r - 7'd7;
      return r[WEEKDAY_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/cmm_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cmm_front
   import cmm_pkg::*;
(
   input  wire logic              req_valid,
   input  wire logic [CMD_W-1:0]  req_cmd,
   input  wire logic [SEL_W-1:0]  req_entry_sel,
   input  wire logic [MASK_W-1:0] req_mask_value,
   input  wire logic              q_full,
   output logic                   req_stall,
   output q_entry_type            push
);

   logic keep;
   op_type op;

   // Classify the request; drop unused codes and loads past the table
   always_comb begin
      keep     = 1'b0;
      op.kind  = KIND_TICK;
      op.field = FLD_MINUTE;
      op.sel   = ENTRY_W'(req_entry_sel);
      op.mask  = req_mask_value;
      unique case (req_cmd) inside
         CMD_LOAD_MINUTE, CMD_LOAD_HOUR, CMD_LOAD_DAY, CMD_LOAD_MONTH,
         CMD_LOAD_WEEKDAY: begin
            keep     = (32'(req_entry_sel) < 32'(ENTRIES));
            op.kind  = KIND_LOAD;
            op.field = field_type'(req_cmd);
         end
         CMD_RESTART: begin
            keep    = 1'b1;
            op.kind = KIND_RESTART;
         end
         CMD_TICK: begin
            keep    = 1'b1;
            op.kind = KIND_TICK;
         end
         default: keep = 1'b0;
      endcase
   end

   assign req_stall  = q_full;
   assign push.valid = req_valid && !q_full && keep;
   assign push.op    = op;

endmodule

`default_nettype wire

// ===== rtl/cmm_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cmm_queue
   import cmm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire q_entry_type push,
   input  wire logic        pop,
   output logic             full,
   output q_entry_type      head
);

   op_type              slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push;

   function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
      return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign full    = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign do_push = push.valid && !full;

   always_comb begin
      wr_ptr_in = do_push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !pop) count_in = count_ff + 1'b1;
      if (!do_push && pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push.op;
   end

   assign head.valid = (count_ff != '0);
   assign head.op    = slot_ff[rd_ptr_ff];

endmodule

`default_nettype wire

// ===== rtl/cmm_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cmm_back
   import cmm_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire q_entry_type           head,
   output logic                       pop,
   input  wire logic                  csr_valid,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [SEL_W-1:0]           rsp_match_entry,
   output logic [YEAR_W-1:0]          rsp_now_year,
   output logic [MONTH_W-1:0]         rsp_now_month,
   output logic [DAY_W-1:0]           rsp_now_day,
   output logic [HOUR_W-1:0]          rsp_now_hour,
   output logic [MINUTE_W-1:0]        rsp_now_minute,
   output logic [WEEKDAY_W-1:0]       rsp_now_weekday,
   output logic                       rsp_last_match
);

   // Schedule table
   logic [MASK_W-1:0]      min_mask_ff [ENTRIES];
   logic [HOUR_MASK_W-1:0] hr_mask_ff  [ENTRIES];
   logic [DAY_MASK_W-1:0]  day_mask_ff [ENTRIES];
   logic [MON_MASK_W-1:0]  mon_mask_ff [ENTRIES];
   logic [WD_MASK_W-1:0]   wd_mask_ff  [ENTRIES];
   logic                   mask_we;

   // Start registers
   logic [YEAR_W-1:0]      st_year_ff;
   logic [MONTH_W-1:0]     st_month_ff;
   logic [DAY_W-1:0]       st_day_ff;
   logic [HOUR_W-1:0]      st_hour_ff;
   logic [MINUTE_W-1:0]    st_minute_ff;

   // Calendar clock
   logic [YEAR_W-1:0]      year_ff, year_in;
   logic [MONTH_W-1:0]     month_ff, month_in;
   logic [DAY_W-1:0]       day_ff, day_in;
   logic [HOUR_W-1:0]      hour_ff, hour_in;
   logic [MINUTE_W-1:0]    minute_ff, minute_in;
   logic [WEEKDAY_W-1:0]   weekday_ff, weekday_in;
   logic [6:0]             mod100_ff, mod100_in;
   logic [8:0]             mod400_ff, mod400_in;

   // Sequencer
   back_state_type         state_ff, state_in;
   logic [YEAR_W-1:0]      tgt_year_ff, tgt_year_in;
   logic [MONTH_W-1:0]     mcount_ff, mcount_in;
   logic [ENTRY_W-1:0]     idx_ff, idx_in;
   logic [ENTRY_W-1:0]     pend_ff, pend_in;
   logic                   pend_valid_ff, pend_valid_in;

   // Result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SEL_W-1:0]       rsp_entry_ff, rsp_entry_in;
   logic [YEAR_W-1:0]      rsp_year_ff, rsp_year_in;
   logic [MONTH_W-1:0]     rsp_month_ff, rsp_month_in;
   logic [DAY_W-1:0]       rsp_day_ff, rsp_day_in;
   logic [HOUR_W-1:0]      rsp_hour_ff, rsp_hour_in;
   logic [MINUTE_W-1:0]    rsp_minute_ff, rsp_minute_in;
   logic [WEEKDAY_W-1:0]   rsp_wd_ff, rsp_wd_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   leap;
   logic                   hit;
   logic                   out_free;
   logic                   advance;
   logic                   push_out;
   logic                   push_last;
   logic [DAY_W-1:0]       day_m1;
   logic [MONTH_W-1:0]     month_m1;

   assign leap     = is_leap(mod100_ff, mod400_ff);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign day_m1   = day_ff - 1'b1;
   assign month_m1 = month_ff - 1'b1;
   assign hit      = min_mask_ff[idx_ff][minute_ff] && hr_mask_ff[idx_ff][hour_ff] &&
                     day_mask_ff[idx_ff][day_m1] && mon_mask_ff[idx_ff][month_m1] &&
                     wd_mask_ff[idx_ff][weekday_ff];

   always_comb begin
      state_in      = state_ff;
      year_in       = year_ff;
      month_in      = month_ff;
      day_in        = day_ff;
      hour_in       = hour_ff;
      minute_in     = minute_ff;
      weekday_in    = weekday_ff;
      mod100_in     = mod100_ff;
      mod400_in     = mod400_ff;
      tgt_year_in   = tgt_year_ff;
      mcount_in     = mcount_ff;
      idx_in        = idx_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      pop           = 1'b0;
      mask_we       = 1'b0;
      advance       = 1'b0;
      push_out      = 1'b0;
      push_last     = 1'b0;

      unique case (state_ff)
         BK_IDLE: begin
            if (head.valid) begin
               pop = 1'b1;
               unique case (head.op.kind)
                  KIND_LOAD: mask_we = 1'b1;
                  KIND_RESTART: begin
                     // Saturate start values, then walk years up from the epoch
                     tgt_year_in = (st_year_ff < EPOCH_YEAR) ? EPOCH_YEAR : st_year_ff;
                     month_in    = (st_month_ff == '0) ? 4'd1 :
                                   ((st_month_ff > 4'd12) ? 4'd12 : st_month_ff);
                     day_in      = (st_day_ff == '0) ? 5'd1 : st_day_ff;
                     hour_in     = (st_hour_ff > 5'd23) ? 5'd23 : st_hour_ff;
                     minute_in   = (st_minute_ff > 6'd59) ? 6'd59 : st_minute_ff;
                     year_in     = EPOCH_YEAR;
                     mod100_in   = EPOCH_MOD100;
                     mod400_in   = EPOCH_MOD400;
                     weekday_in  = EPOCH_WEEKDAY;
                     state_in    = BK_RS_YEAR;
                  end
                  KIND_TICK: begin
                     idx_in        = '0;
                     pend_valid_in = 1'b0;
                     state_in      = BK_SCAN;
                  end
                  default: ;
               endcase
            end
         end

         BK_RS_YEAR: begin
            if (year_ff == tgt_year_ff) begin
               mcount_in = 4'd1;
               state_in  = BK_RS_MONTH;
            end else begin
               weekday_in = mod7(7'(weekday_ff) + (leap ? 7'd2 : 7'd1));
               year_in    = year_ff + 1'b1;
               mod100_in  = (mod100_ff == 7'd99) ? '0 : mod100_ff + 1'b1;
               mod400_in  = (mod400_ff == 9'd399) ? '0 : mod400_ff + 1'b1;
            end
         end

         BK_RS_MONTH: begin
            if (mcount_ff == month_ff) begin
               weekday_in = mod7(7'(weekday_ff) + 7'(day_m1));
               state_in   = BK_IDLE;
            end else begin
               weekday_in = mod7(7'(weekday_ff) + 7'(days_in(leap, mcount_ff)));
               mcount_in  = mcount_ff + 1'b1;
            end
         end

         BK_SCAN: begin
            // Hold a hit until the next one shows whether it was the last
            if (!(hit && pend_valid_ff && !out_free)) begin
               if (hit) begin
                  if (pend_valid_ff) push_out = 1'b1;
                  pend_in       = idx_ff;
                  pend_valid_in = 1'b1;
               end
               if (idx_ff == ENTRY_W'(ENTRIES - 1)) state_in = BK_FLUSH;
               else                                 idx_in   = idx_ff + 1'b1;
            end
         end

         BK_FLUSH: begin
            if (!pend_valid_ff) begin
               advance  = 1'b1;
               state_in = BK_IDLE;
            end else if (out_free) begin
               push_out      = 1'b1;
               push_last     = 1'b1;
               pend_valid_in = 1'b0;
               advance       = 1'b1;
               state_in      = BK_IDLE;
            end
         end

         default: state_in = BK_IDLE;
      endcase

      // Step the clock one minute after the tick's results are out
      if (advance) begin
         if (minute_ff != 6'd59) begin
            minute_in = minute_ff + 1'b1;
         end else begin
            minute_in = '0;
            if (hour_ff != 5'd23) begin
               hour_in = hour_ff + 1'b1;
            end else begin
               hour_in    = '0;
               weekday_in = (weekday_ff == 3'd6) ? '0 : weekday_ff + 1'b1;
               if (day_ff < days_in(leap, month_ff)) begin
                  day_in = day_ff + 1'b1;
               end else begin
                  day_in = 5'd1;
                  if (month_ff != 4'd12) begin
                     month_in = month_ff + 1'b1;
                  end else begin
                     month_in = 4'd1;
                     if (year_ff != MAX_YEAR) begin
                        year_in   = year_ff + 1'b1;
                        mod100_in = (mod100_ff == 7'd99) ? '0 : mod100_ff + 1'b1;
                        mod400_in = (mod400_ff == 9'd399) ? '0 : mod400_ff + 1'b1;
                     end
                  end
               end
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in  = (rsp_valid_ff && !rsp_stall) ? 1'b0 : rsp_valid_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_year_in   = rsp_year_ff;
      rsp_month_in  = rsp_month_ff;
      rsp_day_in    = rsp_day_ff;
      rsp_hour_in   = rsp_hour_ff;
      rsp_minute_in = rsp_minute_ff;
      rsp_wd_in     = rsp_wd_ff;
      rsp_last_in   = rsp_last_ff;
      if (push_out) begin
         rsp_valid_in  = 1'b1;
         rsp_entry_in  = SEL_W'(pend_ff);
         rsp_year_in   = year_ff;
         rsp_month_in  = month_ff;
         rsp_day_in    = day_ff;
         rsp_hour_in   = hour_ff;
         rsp_minute_in = minute_ff;
         rsp_wd_in     = weekday_ff;
         rsp_last_in   = push_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_IDLE;
         year_ff       <= EPOCH_YEAR;
         month_ff      <= 4'd1;
         day_ff        <= 5'd1;
         hour_ff       <= '0;
         minute_ff     <= '0;
         weekday_ff    <= EPOCH_WEEKDAY;
         mod100_ff     <= EPOCH_MOD100;
         mod400_ff     <= EPOCH_MOD400;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         year_ff       <= year_in;
         month_ff      <= month_in;
         day_ff        <= day_in;
         hour_ff       <= hour_in;
         minute_ff     <= minute_in;
         weekday_ff    <= weekday_in;
         mod100_ff     <= mod100_in;
         mod400_ff     <= mod400_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tgt_year_ff   <= tgt_year_in;
      mcount_ff     <= mcount_in;
      idx_ff        <= idx_in;
      pend_ff       <= pend_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_year_ff   <= rsp_year_in;
      rsp_month_ff  <= rsp_month_in;
      rsp_day_ff    <= rsp_day_in;
      rsp_hour_ff   <= rsp_hour_in;
      rsp_minute_ff <= rsp_minute_in;
      rsp_wd_ff     <= rsp_wd_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_year_ff   <= EPOCH_YEAR;
         st_month_ff  <= 4'd1;
         st_day_ff    <= 5'd1;
         st_hour_ff   <= '0;
         st_minute_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_START_YEAR:   st_year_ff   <= csr_data;
            CSR_START_MONTH:  st_month_ff  <= csr_data[MONTH_W-1:0];
            CSR_START_DAY:    st_day_ff    <= csr_data[DAY_W-1:0];
            CSR_START_HOUR:   st_hour_ff   <= csr_data[HOUR_W-1:0];
            CSR_START_MINUTE: st_minute_ff <= csr_data[MINUTE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            min_mask_ff[i] <= '0;
            hr_mask_ff[i]  <= '0;
            day_mask_ff[i] <= '0;
            mon_mask_ff[i] <= '0;
            wd_mask_ff[i]  <= '0;
         end
      end else if (mask_we) begin
         unique case (head.op.field)
            FLD_MINUTE:  min_mask_ff[head.op.sel] <= head.op.mask;
            FLD_HOUR:    hr_mask_ff[head.op.sel]  <= head.op.mask[HOUR_MASK_W-1:0];
            FLD_DAY:     day_mask_ff[head.op.sel] <= head.op.mask[DAY_MASK_W-1:0];
            FLD_MONTH:   mon_mask_ff[head.op.sel] <= head.op.mask[MON_MASK_W-1:0];
            FLD_WEEKDAY: wd_mask_ff[head.op.sel]  <= head.op.mask[WD_MASK_W-1:0];
            default: ;
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_match_entry = rsp_entry_ff;
   assign rsp_now_year    = rsp_year_ff;
   assign rsp_now_month   = rsp_month_ff;
   assign rsp_now_day     = rsp_day_ff;
   assign rsp_now_hour    = rsp_hour_ff;
   assign rsp_now_minute  = rsp_minute_ff;
   assign rsp_now_weekday = rsp_wd_ff;
   assign rsp_last_match  = rsp_last_ff;

endmodule

`default_nettype wire

// ===== rtl/cron_minute_matcher_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Cron-style minute matcher: a Gregorian calendar clock at minute resolution
// checked against a 16-entry table of minute/hour/day/month/weekday masks.
// Requests (commands 0-4 load a mask, 5 restarts the clock from the start
// registers, 6 ticks) are classified at the front and queued two deep; the
// back end executes them in order. A tick scans the table one entry per
// cycle, pausing when a match must wait for the result side; each matching
// entry yields one response in index order, the final one flagged by
// rsp_last_match, and the clock then steps one minute. A restart walks the
// year counter up from 1970 one year per cycle and then the months one per
// cycle. Requests with code 7 or a mask load for an entry past the table
// are dropped. Start registers are sampled when a restart begins executing;
// csr_ready is always high.

module cron_minute_matcher_unit
   import cmm_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [CMD_W-1:0]      req_cmd,
   input  wire logic [SEL_W-1:0]      req_entry_sel,
   input  wire logic [MASK_W-1:0]     req_mask_value,

   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [SEL_W-1:0]           rsp_match_entry,
   output logic [YEAR_W-1:0]          rsp_now_year,
   output logic [MONTH_W-1:0]         rsp_now_month,
   output logic [DAY_W-1:0]           rsp_now_day,
   output logic [HOUR_W-1:0]          rsp_now_hour,
   output logic [MINUTE_W-1:0]        rsp_now_minute,
   output logic [WEEKDAY_W-1:0]       rsp_now_weekday,
   output logic                       rsp_last_match,

   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   q_entry_type push;
   q_entry_type head;
   logic        q_full;
   logic        pop;

   // Writes never wait: the start registers are plain flops
   assign csr_ready = 1'b1;

   // Front: decode the request, drop the ones that do nothing
   cmm_front u_front (
      .req_valid      (req_valid),
      .req_cmd        (req_cmd),
      .req_entry_sel  (req_entry_sel),
      .req_mask_value (req_mask_value),
      .q_full         (q_full),
      .req_stall      (req_stall),
      .push           (push)
   );

   // Queue: decouple request acceptance from execution
   cmm_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .full  (q_full),
      .head  (head)
   );

   // Back: mask table, calendar clock, restart walk and tick scan
   cmm_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .pop             (pop),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_match_entry (rsp_match_entry),
      .rsp_now_year    (rsp_now_year),
      .rsp_now_month   (rsp_now_month),
      .rsp_now_day     (rsp_now_day),
      .rsp_now_hour    (rsp_now_hour),
      .rsp_now_minute  (rsp_now_minute),
      .rsp_now_weekday (rsp_now_weekday),
      .rsp_last_match  (rsp_last_match)
   );

endmodule

`default_nettype wire
